[src/vnf_pkg.sv]
// Shared constants, types and hash helpers for the 2D value noise fBm block.
// Used by vnf_front, vnf_octave, vnf_div and value_noise_fbm_2d.
package vnf_pkg;

   localparam int MAX_OCTAVES     = 16;
   localparam int COORD_FRAC_BITS = 16;

   localparam int OCT_W  = ($clog2(MAX_OCTAVES + 1) > 5) ? $clog2(MAX_OCTAVES + 1) : 5;
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int NUM_STG = 10;
   localparam int VAL_W   = 16;
   localparam int PROD_W  = VAL_W + 32;
   localparam int TOT_W   = PROD_W + $clog2(MAX_OCTAVES + 1);
   localparam int AMPT_W  = 32 + $clog2(MAX_OCTAVES + 1);
   localparam int REM_W   = TOT_W + 1;
   localparam int DIV_STG = VAL_W;
   localparam int PEXT_W  = COORD_FRAC_BITS + 48;

   localparam logic [31:0] FREQ_ONE     = 32'h0001_0000;
   localparam logic [15:0] LAC_DEFAULT  = 16'd8192;
   localparam logic [15:0] GAIN_DEFAULT = 16'd8192;
   localparam logic [4:0]  OCT_DEFAULT  = 5'd4;
   localparam logic [31:0] SEED_STEP    = 32'd1013904223;
   localparam logic [31:0] MIX_K1       = 32'h7feb_352d;
   localparam logic [31:0] MIX_K2       = 32'h846c_a68b;
   localparam logic [31:0] HASH_CX      = 32'h8da6_b343;
   localparam logic [31:0] HASH_CY      = 32'hd816_3841;

   localparam int CSR_AW = 4;

   typedef enum logic [1:0] {
      CSR_SEED    = 2'd0,
      CSR_OCTAVES = 2'd1,
      CSR_LAC     = 2'd2,
      CSR_GAIN    = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [31:0]      x;
      logic [31:0]      y;
      logic [OCT_W-1:0] n;
      logic             zero;
   } item_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] freq;
      logic [31:0] seed;
      logic [31:0] amp;
      logic        last;
      logic        zero;
   } issue_type;

   typedef struct packed {
      logic [31:0] seed;
      logic [31:0] amp;
      logic        last;
      logic        zero;
   } side_type;

   typedef struct packed {
      logic [PROD_W-1:0] prod;
      logic [31:0]       amp;
      logic              last;
      logic              zero;
   } oct_out_type;

   // xor-shift-multiply finalizer, split at its multipliers
   function automatic logic [31:0] mix_a(input logic [31:0] v);
      logic [31:0] t;
      t = v ^ (v >> 16);
      return t * MIX_K1;
   endfunction

   function automatic logic [31:0] mix_b(input logic [31:0] v);
      logic [31:0] t;
      t = v ^ (v >> 15);
      return t * MIX_K2;
   endfunction

   function automatic logic [31:0] mix_c(input logic [31:0] v);
      return v ^ (v >> 16);
   endfunction

endpackage

[src/vnf_front.sv]
// Front end: accepts sample transfers, resolves the octave count, queues items.
// Depends on vnf_pkg.
module vnf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [31:0]       req_sample_x,
   input  logic [31:0]       req_sample_y,
   input  logic [4:0]        octave_count,
   input  logic              q_pop,
   output logic              q_valid,
   output vnf_pkg::item_type q_item
);

   vnf_pkg::item_type               mem_ff [vnf_pkg::QDEPTH];
   vnf_pkg::item_type               ent;
   logic [vnf_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [vnf_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic [vnf_pkg::OCT_W-1:0]       n_raw;
   logic                            push;

   assign req_stall = (count_ff == vnf_pkg::QCNT_W'(vnf_pkg::QDEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_item    = mem_ff[rd_ptr_ff];
   assign push      = req_valid & ~req_stall;

   always_comb begin
      n_raw    = vnf_pkg::OCT_W'(octave_count);
      ent.x    = req_sample_x;
      ent.y    = req_sample_y;
      ent.n    = (n_raw > vnf_pkg::OCT_W'(vnf_pkg::MAX_OCTAVES)) ?
                 vnf_pkg::OCT_W'(vnf_pkg::MAX_OCTAVES) : n_raw;
      ent.zero = (n_raw == '0);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == vnf_pkg::QPTR_W'(vnf_pkg::QDEPTH - 1)) ? '0 :
                     wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == vnf_pkg::QPTR_W'(vnf_pkg::QDEPTH - 1)) ? '0 :
                     rd_ptr_ff + 1'b1;
      end
      case ({push, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= ent;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= vnf_pkg::QCNT_W'(vnf_pkg::QDEPTH))
      else $error("item queue count above depth");

endmodule

[src/vnf_octave.sv]
// Octave datapath: coordinate scaling, corner hashes, quintic weights, blend.
// Ten stages, one octave enters per advancing cycle. Depends on vnf_pkg.
module vnf_octave (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 iss_valid,
   input  vnf_pkg::issue_type   iss,
   output logic                 oct_valid,
   output vnf_pkg::oct_out_type oct_out
);

   localparam int CF       = vnf_pkg::COORD_FRAC_BITS;
   localparam int PEXT_W_L = vnf_pkg::PEXT_W;

   logic [vnf_pkg::NUM_STG-1:0] vld_ff, vld_in;
   vnf_pkg::side_type           side_ff [vnf_pkg::NUM_STG];
   vnf_pkg::side_type           side_in [vnf_pkg::NUM_STG];

   logic signed [48:0] pxl_ff, pxh_ff, pyl_ff, pyh_ff, pxl_in, pxh_in, pyl_in, pyh_in;
   logic signed [48:0] xe, ye, fl, fh;
   logic signed [63:0] px, py;
   logic signed [PEXT_W_L-1:0] pxe, pye;

   logic [31:0]            cx_ff, cy_ff, cx_in, cy_in;
   logic [1:0][15:0]       fr_ff, fr_in;
   logic [1:0][31:0]       ax_ff, ax_in, ay3_ff, ay3_in, tt_ff, tt_in;
   logic [1:0][35:0]       m_ff, m_in;
   logic [1:0][15:0]       t3_ff, t3_in;
   logic [1:0][31:0]       hx4_ff, hx4_in, ay4_ff, ay4_in, cube_ff, cube_in;
   logic [1:0][19:0]       inner_ff, inner_in;
   logic [1:0][31:0]       hx5_ff, hx5_in, ay5_ff, ay5_in;
   logic [1:0][16:0]       w5_ff, w5_in, w6_ff, w6_in, w7_ff, w7_in;
   logic [1:0][51:0]       wp;
   logic [1:0][19:0]       wr;
   logic [3:0][31:0]       u6_ff, u6_in, u7_ff, u7_in, cn;
   logic [3:0][48:0]       b8_ff, b8_in;
   logic [16:0]            wy8_ff, wy8_in, nwx;
   logic [1:0][48:0]       q9_ff, q9_in;
   logic [31:0]            top, bot;
   logic [15:0]            val;
   logic [vnf_pkg::PROD_W-1:0] prod_ff, prod_in;

   always_comb begin
      vld_in[0]           = iss_valid;
      side_in[0].seed     = iss.seed;
      side_in[0].amp      = iss.amp;
      side_in[0].last     = iss.last;
      side_in[0].zero     = iss.zero;
      for (int i = 1; i < vnf_pkg::NUM_STG; i++) begin
         vld_in[i]  = vld_ff[i-1];
         side_in[i] = side_ff[i-1];
      end
   end

   // scaled coordinate as two 32x16 partial products
   always_comb begin
      xe     = 49'($signed(iss.x));
      ye     = 49'($signed(iss.y));
      fl     = $signed({33'd0, iss.freq[15:0]});
      fh     = $signed({33'd0, iss.freq[31:16]});
      pxl_in = xe * fl;
      pxh_in = xe * fh;
      pyl_in = ye * fl;
      pyh_in = ye * fh;
   end

   always_comb begin
      px       = ($signed(64'(pxh_ff)) <<< 16) + $signed(64'(pxl_ff));
      py       = ($signed(64'(pyh_ff)) <<< 16) + $signed(64'(pyl_ff));
      pxe      = PEXT_W_L'(px);
      pye      = PEXT_W_L'(py);
      cx_in    = pxe[CF+47:CF+16];
      cy_in    = pye[CF+47:CF+16];
      fr_in[0] = pxe[CF+15:CF];
      fr_in[1] = pye[CF+15:CF];
   end

   always_comb begin
      ax_in[0]  = cx_ff * vnf_pkg::HASH_CX;
      ax_in[1]  = (cx_ff + 32'd1) * vnf_pkg::HASH_CX;
      ay3_in[0] = cy_ff * vnf_pkg::HASH_CY;
      ay3_in[1] = (cy_ff + 32'd1) * vnf_pkg::HASH_CY;
      for (int j = 0; j < 2; j++) begin
         tt_in[j] = 32'(fr_ff[j]) * 32'(fr_ff[j]);
         m_in[j]  = 36'(fr_ff[j]) * (36'd983040 - 36'(fr_ff[j]) * 36'd6);
         t3_in[j] = fr_ff[j];
      end
   end

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         hx4_in[i]   = vnf_pkg::mix_a(side_ff[2].seed ^ ax_ff[i]);
         ay4_in[i]   = ay3_ff[i];
         inner_in[i] = 20'd655360 - 20'(m_ff[i] >> 16);
         cube_in[i]  = 32'((48'(tt_ff[i]) * 48'(t3_ff[i])) >> 16);
      end
   end

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         hx5_in[i] = vnf_pkg::mix_b(hx4_ff[i]);
         ay5_in[i] = ay4_ff[i];
         wp[i]     = 52'(cube_ff[i]) * 52'(inner_ff[i]) + 52'h8000_0000;
         wr[i]     = 20'(wp[i] >> 32);
         w5_in[i]  = (wr[i] > 20'd65536) ? 17'd65536 : 17'(wr[i]);
      end
   end

   // corners: 0 (cx,cy) 1 (cx+1,cy) 2 (cx,cy+1) 3 (cx+1,cy+1)
   always_comb begin
      u6_in[0] = vnf_pkg::mix_a(vnf_pkg::mix_c(hx5_ff[0]) ^ ay5_ff[0]);
      u6_in[1] = vnf_pkg::mix_a(vnf_pkg::mix_c(hx5_ff[1]) ^ ay5_ff[0]);
      u6_in[2] = vnf_pkg::mix_a(vnf_pkg::mix_c(hx5_ff[0]) ^ ay5_ff[1]);
      u6_in[3] = vnf_pkg::mix_a(vnf_pkg::mix_c(hx5_ff[1]) ^ ay5_ff[1]);
      w6_in    = w5_ff;
      for (int i = 0; i < 4; i++) begin
         u7_in[i] = vnf_pkg::mix_b(u6_ff[i]);
      end
      w7_in    = w6_ff;
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         cn[i] = vnf_pkg::mix_c(u7_ff[i]);
      end
      nwx      = 17'd65536 - w7_ff[0];
      b8_in[0] = 49'(cn[0]) * 49'(nwx);
      b8_in[1] = 49'(cn[1]) * 49'(w7_ff[0]);
      b8_in[2] = 49'(cn[2]) * 49'(nwx);
      b8_in[3] = 49'(cn[3]) * 49'(w7_ff[0]);
      wy8_in   = w7_ff[1];
   end

   always_comb begin
      top      = 32'((50'(b8_ff[0]) + 50'(b8_ff[1]) + 50'h8000) >> 16);
      bot      = 32'((50'(b8_ff[2]) + 50'(b8_ff[3]) + 50'h8000) >> 16);
      q9_in[0] = 49'(top) * 49'(17'd65536 - wy8_ff);
      q9_in[1] = 49'(bot) * 49'(wy8_ff);
      val      = 16'((50'(q9_ff[0]) + 50'(q9_ff[1]) + 50'h8000) >> 32);
      prod_in  = vnf_pkg::PROD_W'(val) * vnf_pkg::PROD_W'(side_ff[8].amp);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < vnf_pkg::NUM_STG; i++) begin
            side_ff[i] <= side_in[i];
         end
         pxl_ff   <= pxl_in;
         pxh_ff   <= pxh_in;
         pyl_ff   <= pyl_in;
         pyh_ff   <= pyh_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         fr_ff    <= fr_in;
         ax_ff    <= ax_in;
         ay3_ff   <= ay3_in;
         tt_ff    <= tt_in;
         m_ff     <= m_in;
         t3_ff    <= t3_in;
         hx4_ff   <= hx4_in;
         ay4_ff   <= ay4_in;
         inner_ff <= inner_in;
         cube_ff  <= cube_in;
         hx5_ff   <= hx5_in;
         ay5_ff   <= ay5_in;
         w5_ff    <= w5_in;
         u6_ff    <= u6_in;
         w6_ff    <= w6_in;
         u7_ff    <= u7_in;
         w7_ff    <= w7_in;
         b8_ff    <= b8_in;
         wy8_ff   <= wy8_in;
         q9_ff    <= q9_in;
         prod_ff  <= prod_in;
      end
   end

   assign oct_valid    = vld_ff[vnf_pkg::NUM_STG-1];
   assign oct_out.prod = prod_ff;
   assign oct_out.amp  = side_ff[vnf_pkg::NUM_STG-1].amp;
   assign oct_out.last = side_ff[vnf_pkg::NUM_STG-1].last;
   assign oct_out.zero = side_ff[vnf_pkg::NUM_STG-1].zero;

endmodule

[src/vnf_div.sv]
// Pipelined rounding divider: weighted sum over amplitude sum, one quotient
// bit per stage after the rounding stage. Depends on vnf_pkg.
module vnf_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  logic                       in_zero,
   input  logic [vnf_pkg::TOT_W-1:0]  in_total,
   input  logic [vnf_pkg::AMPT_W-1:0] in_amp,
   output logic                       out_valid,
   output logic [vnf_pkg::VAL_W-1:0]  out_value
);

   localparam int NS = vnf_pkg::DIV_STG + 1;

   logic [NS-1:0]                 vld_ff, vld_in, zero_ff, zero_in;
   logic [vnf_pkg::REM_W-1:0]     rem_ff [NS];
   logic [vnf_pkg::REM_W-1:0]     rem_in [NS];
   logic [vnf_pkg::AMPT_W-1:0]    den_ff [NS];
   logic [vnf_pkg::AMPT_W-1:0]    den_in [NS];
   logic [vnf_pkg::VAL_W-1:0]     q_ff [NS];
   logic [vnf_pkg::VAL_W-1:0]     q_in [NS];
   logic [vnf_pkg::REM_W-1:0]     dsh [NS];
   logic [NS-1:0]                 ge;

   always_comb begin
      vld_in[0]  = in_valid;
      zero_in[0] = in_zero;
      rem_in[0]  = vnf_pkg::REM_W'(in_total) + vnf_pkg::REM_W'(in_amp >> 1);
      den_in[0]  = in_amp;
      q_in[0]    = '0;
      dsh[0]     = '0;
      ge[0]      = 1'b0;
      for (int i = 1; i < NS; i++) begin
         dsh[i]     = vnf_pkg::REM_W'(den_ff[i-1]) << (vnf_pkg::DIV_STG - i);
         ge[i]      = (rem_ff[i-1] >= dsh[i]);
         rem_in[i]  = ge[i] ? rem_ff[i-1] - dsh[i] : rem_ff[i-1];
         q_in[i]    = {q_ff[i-1][vnf_pkg::VAL_W-2:0], ge[i]};
         den_in[i]  = den_ff[i-1];
         vld_in[i]  = vld_ff[i-1];
         zero_in[i] = zero_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zero_ff <= zero_in;
         for (int i = 0; i < NS; i++) begin
            rem_ff[i] <= rem_in[i];
            den_ff[i] <= den_in[i];
            q_ff[i]   <= q_in[i];
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_value = zero_ff[NS-1] ? '0 : q_ff[NS-1];

endmodule

[src/value_noise_fbm_2d.sv]
// Top level of the 2D value noise fBm block: registers, octave sequencer,
// accumulator and result register. Depends on vnf_pkg, vnf_front, vnf_octave, vnf_div.
//
// Use: a sample point (req_sample_x, req_sample_y, signed Q16.16) transfers
// when req_valid is high and req_stall low. One result, rsp_noise_value in
// unsigned Q0.16, transfers when rsp_valid is high and rsp_stall low, in
// input order. The user writes registers over the csr_ port only while the block
// is idle; the block does not enforce this. The octaves of an item (count capped
// at 16) go one per cycle unless rsp_stall holds the back end, through a single
// octave datapath; the next item is taken as the last octave issues. Path: queue,
// ten octave stages, accumulator, seventeen divider stages, result register.
// A four-entry input queue takes items while the back end works or stalls.
// When rsp_stall holds a result, the back end freezes in place; the queue
// keeps taking items until it is full, then raises req_stall.
// Reset is synchronous: pipelines empty, registers to seed 0, four octaves,
// lacunarity 2.0 and gain 0.5.
module value_noise_fbm_2d (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [31:0]                 req_sample_x,
   input  logic [31:0]                 req_sample_y,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [15:0]                 rsp_noise_value,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [vnf_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   logic [31:0] seed_ff;
   logic [4:0]  octaves_ff;
   logic [15:0] lac_ff, gain_ff, lac_eff, gain_eff;
   vnf_pkg::csr_idx_type csr_idx;
   logic        csr_wr;

   logic                      adv, q_valid, q_pop;
   vnf_pkg::item_type         q_item;

   logic                      busy_ff, busy_in, issue_last;
   vnf_pkg::item_type         cur_ff, cur_in;
   logic [vnf_pkg::OCT_W-1:0] k_ff, k_in;
   logic [31:0]               freq_ff, freq_in, amp_ff, amp_in, oseed_ff, oseed_in;
   logic [47:0]               fprod, aprod;
   logic [35:0]               fsh;
   logic [33:0]               ash;
   vnf_pkg::issue_type        iss;

   logic                      oct_valid;
   vnf_pkg::oct_out_type      oct_out;

   logic [vnf_pkg::TOT_W-1:0]  acc_ff, acc_in, fin_tot_ff, fin_tot_in, sum_tot;
   logic [vnf_pkg::AMPT_W-1:0] amp_acc_ff, amp_acc_in, fin_amp_ff, fin_amp_in, sum_amp;
   logic                       fin_vld_ff, fin_vld_in, fin_zero_ff, fin_zero_in;

   logic        div_valid;
   logic [15:0] div_value;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_value_ff, rsp_value_in;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_idx    = vnf_pkg::csr_idx_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      case (csr_idx)
         vnf_pkg::CSR_SEED:    csr_prdata = seed_ff;
         vnf_pkg::CSR_OCTAVES: csr_prdata = {27'd0, octaves_ff};
         vnf_pkg::CSR_LAC:     csr_prdata = {16'd0, lac_ff};
         vnf_pkg::CSR_GAIN:    csr_prdata = {16'd0, gain_ff};
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff    <= '0;
         octaves_ff <= vnf_pkg::OCT_DEFAULT;
         lac_ff     <= vnf_pkg::LAC_DEFAULT;
         gain_ff    <= vnf_pkg::GAIN_DEFAULT;
      end else if (csr_wr) begin
         case (csr_idx)
            vnf_pkg::CSR_SEED:    seed_ff    <= csr_pwdata;
            vnf_pkg::CSR_OCTAVES: octaves_ff <= csr_pwdata[4:0];
            vnf_pkg::CSR_LAC:     lac_ff     <= csr_pwdata[15:0];
            vnf_pkg::CSR_GAIN:    gain_ff    <= csr_pwdata[15:0];
            default:              seed_ff    <= seed_ff;
         endcase
      end
   end

   assign lac_eff  = (lac_ff == '0) ? vnf_pkg::LAC_DEFAULT : lac_ff;
   assign gain_eff = (gain_ff == '0) ? vnf_pkg::GAIN_DEFAULT : gain_ff;

   // whole back end advances unless a held result blocks it
   assign adv = ~rsp_valid_ff | ~rsp_stall;

   vnf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample_x (req_sample_x),
      .req_sample_y (req_sample_y),
      .octave_count (octaves_ff),
      .q_pop        (q_pop),
      .q_valid      (q_valid),
      .q_item       (q_item)
   );

   // octave sequencer
   assign issue_last = cur_ff.zero || (k_ff == cur_ff.n - 1'b1);
   assign q_pop      = adv & q_valid & (~busy_ff | issue_last);

   always_comb begin
      fprod    = 48'(freq_ff) * 48'(lac_eff) + 48'h800;
      fsh      = 36'(fprod >> 12);
      aprod    = 48'(amp_ff) * 48'(gain_eff) + 48'h2000;
      ash      = 34'(aprod >> 14);
      busy_in  = busy_ff;
      cur_in   = cur_ff;
      k_in     = k_ff;
      freq_in  = freq_ff;
      amp_in   = amp_ff;
      oseed_in = oseed_ff;
      if (adv) begin
         if (busy_ff && !issue_last) begin
            k_in     = k_ff + 1'b1;
            freq_in  = (fsh[35:32] != '0) ? 32'hffff_ffff : fsh[31:0];
            amp_in   = (ash[33:32] != '0) ? 32'hffff_ffff : ash[31:0];
            oseed_in = oseed_ff + vnf_pkg::SEED_STEP;
         end else begin
            busy_in  = q_valid;
            cur_in   = q_item;
            k_in     = '0;
            freq_in  = vnf_pkg::FREQ_ONE;
            amp_in   = vnf_pkg::FREQ_ONE;
            oseed_in = seed_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      k_ff     <= k_in;
      freq_ff  <= freq_in;
      amp_ff   <= amp_in;
      oseed_ff <= oseed_in;
   end

   always_comb begin
      iss.x    = cur_ff.x;
      iss.y    = cur_ff.y;
      iss.freq = freq_ff;
      iss.seed = oseed_ff;
      iss.amp  = amp_ff;
      iss.last = issue_last;
      iss.zero = cur_ff.zero;
   end

   vnf_octave u_octave (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .iss_valid (busy_ff),
      .iss       (iss),
      .oct_valid (oct_valid),
      .oct_out   (oct_out)
   );

   // octave accumulator
   always_comb begin
      sum_tot     = acc_ff + vnf_pkg::TOT_W'(oct_out.prod);
      sum_amp     = amp_acc_ff + vnf_pkg::AMPT_W'(oct_out.amp);
      acc_in      = acc_ff;
      amp_acc_in  = amp_acc_ff;
      fin_vld_in  = fin_vld_ff;
      fin_tot_in  = fin_tot_ff;
      fin_amp_in  = fin_amp_ff;
      fin_zero_in = fin_zero_ff;
      if (adv) begin
         fin_vld_in = oct_valid & oct_out.last;
         if (oct_valid) begin
            if (oct_out.last) begin
               acc_in      = '0;
               amp_acc_in  = '0;
               fin_tot_in  = sum_tot;
               fin_amp_in  = sum_amp;
               fin_zero_in = oct_out.zero;
            end else begin
               acc_in     = sum_tot;
               amp_acc_in = sum_amp;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         amp_acc_ff <= '0;
         fin_vld_ff <= 1'b0;
      end else begin
         acc_ff     <= acc_in;
         amp_acc_ff <= amp_acc_in;
         fin_vld_ff <= fin_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_tot_ff  <= fin_tot_in;
      fin_amp_ff  <= fin_amp_in;
      fin_zero_ff <= fin_zero_in;
   end

   vnf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fin_vld_ff),
      .in_zero   (fin_zero_ff),
      .in_total  (fin_tot_ff),
      .in_amp    (fin_amp_ff),
      .out_valid (div_valid),
      .out_value (div_value)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (adv) begin
         rsp_valid_in = div_valid;
         rsp_value_in = div_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;

   a_octave_index: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !cur_ff.zero |-> k_ff < cur_ff.n)
      else $error("octave index beyond octave count");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      fin_vld_ff && !fin_zero_ff |-> fin_amp_ff >= vnf_pkg::AMPT_W'(vnf_pkg::FREQ_ONE))
      else $error("amplitude sum below first octave amplitude");

   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      adv && oct_valid && oct_out.last |=> acc_ff == '0 && amp_acc_ff == '0)
      else $error("accumulator not cleared after last octave");

endmodule
